FILE: design/length_framed_crc16_deframer_core_defines.svh
// assertion macros for the length framed crc16 deframer
// expects signals named clk and rst_n in the scope of use
`ifndef LENGTH_FRAMED_CRC16_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_FRAMED_CRC16_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LFCD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LFCD_ASSERT(lbl, prop, msg)
`define LFCD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: design/lfcd_pkg.sv
// shared types and constants of the length framed crc16 deframer
// no dependencies
package lfcd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX    = 2'd2;

  typedef enum logic [2:0] {
    ROLE_DISCARD  = 3'd0,
    ROLE_HEADER   = 3'd1,
    ROLE_LENGTH   = 3'd2,
    ROLE_PAYLOAD  = 3'd3,
    ROLE_CRC_LO   = 3'd4,
    ROLE_CRC_HI   = 3'd5,
    ROLE_REJECTED = 3'd6
  } lfcd_role_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] min_length;
    logic [7:0] max_length;
  } lfcd_cfg_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    lfcd_role_t byte_role;
    logic [8:0] frame_position;
    logic       frame_good;
  } lfcd_res_t;

endpackage

FILE: design/lfcd_in_stage.sv
// input register stage: holds one received byte until the parser takes it
// depends on nothing
module lfcd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_tready  = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

endmodule

FILE: design/lfcd_parser.sv
// frame parser: phase, length count, position and running crc16 ccitt
// depends on lfcd_pkg
module lfcd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  lfcd_pkg::lfcd_cfg_t cfg,
  output lfcd_pkg::lfcd_res_t res
);
  import lfcd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CRCL = 3'd3,
    PH_CRCH = 3'd4
  } phase_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  phase_t      phase_r,      phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [8:0]  position_r,   position_nxt;
  logic [15:0] crc_r,        crc_nxt;
  logic [7:0]  crc_low_r,    crc_low_nxt;
  logic [7:0]  left_dec;
  logic [8:0]  pos_inc;

  assign left_dec = bytes_left_r - 8'd1;
  assign pos_inc  = position_r + 9'd1;

  always_comb begin
    phase_nxt          = PH_HUNT;
    bytes_left_nxt     = bytes_left_r;
    position_nxt       = position_r;
    crc_nxt            = crc_r;
    crc_low_nxt        = crc_low_r;
    res.echo_byte      = rx_byte;
    res.byte_role      = ROLE_DISCARD;
    res.frame_position = 9'd0;
    res.frame_good     = 1'b0;
    case (phase_r)
      PH_LEN: begin
        position_nxt       = 9'd1;
        res.frame_position = 9'd1;
        if (rx_byte != 8'd0 && rx_byte >= cfg.min_length && rx_byte <= cfg.max_length) begin
          res.byte_role  = ROLE_LENGTH;
          bytes_left_nxt = rx_byte;
          crc_nxt        = crc_upd(CRC_INIT, rx_byte);
          phase_nxt      = PH_DATA;
        end else begin
          res.byte_role = ROLE_REJECTED;
        end
      end
      PH_DATA: begin
        position_nxt       = pos_inc;
        res.frame_position = pos_inc;
        res.byte_role      = ROLE_PAYLOAD;
        crc_nxt            = crc_upd(crc_r, rx_byte);
        bytes_left_nxt     = left_dec;
        phase_nxt          = (left_dec == 8'd0) ? PH_CRCL : PH_DATA;
      end
      PH_CRCL: begin
        position_nxt       = pos_inc;
        res.frame_position = pos_inc;
        res.byte_role      = ROLE_CRC_LO;
        crc_low_nxt        = rx_byte;
        phase_nxt          = PH_CRCH;
      end
      PH_CRCH: begin
        position_nxt       = pos_inc;
        res.frame_position = pos_inc;
        res.byte_role      = ROLE_CRC_HI;
        res.frame_good     = ({rx_byte, crc_low_r} == crc_r);
      end
      default: begin
        position_nxt = 9'd0;
        if (rx_byte == cfg.header_value) begin
          res.byte_role = ROLE_HEADER;
          crc_nxt       = CRC_INIT;
          phase_nxt     = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      bytes_left_r <= 8'd0;
      position_r   <= 9'd0;
      crc_r        <= CRC_INIT;
      crc_low_r    <= 8'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      position_r   <= position_nxt;
      crc_r        <= crc_nxt;
      crc_low_r    <= crc_low_nxt;
    end
  end

endmodule

FILE: design/length_framed_crc16_deframer_core.sv
// top level of the length framed crc16 deframer: registers, channels, output stage
// depends on lfcd_pkg, lfcd_in_stage, lfcd_parser and the assertion header
//
// in_*  : one received byte per transaction, in_tdata[7:0]
// out_* : one tagged byte per input transaction, same order
//         tdata = echo byte and frame position, tuser = role and crc verdict
// cfg_* : register writes, index 0 header byte, 1 min length, 2 max length;
//         other indexes are ignored, cfg_ready is always high
// data flow: an accepted byte waits in the input register, passes the parser and is registered again for out_*
// throughput: one byte per cycle while out_tready is high; the path between input and output register
//   is the single byte crc16 update and the length compares
// reset: synchronous active low; clears both channels, the parser returns to
//   header hunt with crc 0xffff, registers go to header 0, min 1, max 255
// stall: while out_tready is low the result is held, one more byte waits in
//   the input register, then in_tready drops until the output is taken
`include "length_framed_crc16_deframer_core_defines.svh"

module length_framed_crc16_deframer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [7:0] echo_byte, [16:8] frame_position, zero
  output logic [3:0]                    out_tuser,  // [2:0] byte_role, [3] frame_good
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import lfcd_pkg::*;

  lfcd_cfg_t  cfg_r;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       out_free;
  logic       advance;
  lfcd_res_t  res;
  lfcd_res_t  out_r;
  logic       out_valid_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = hold_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value <= 8'd0;
      cfg_r.min_length   <= 8'd1;
      cfg_r.max_length   <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_HEADER: cfg_r.header_value <= cfg_data;
        CFG_IDX_MIN:    cfg_r.min_length   <= cfg_data;
        CFG_IDX_MAX:    cfg_r.max_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  lfcd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  lfcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (hold_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.frame_position, out_r.echo_byte};
  assign out_tuser  = {out_r.frame_good, out_r.byte_role};

  `LFCD_ASSERT_NEVER(a_good_only_on_crc_hi,
    out_valid_r && out_r.frame_good && out_r.byte_role != ROLE_CRC_HI,
    "crc verdict set on a byte that is not the high crc byte")
  `LFCD_ASSERT_NEVER(a_hunt_pos_zero,
    out_valid_r && (out_r.byte_role == ROLE_DISCARD || out_r.byte_role == ROLE_HEADER)
      && out_r.frame_position != 9'd0,
    "hunt byte reported away from position zero")
  `LFCD_ASSERT_NEVER(a_len_pos_one,
    out_valid_r && (out_r.byte_role == ROLE_LENGTH || out_r.byte_role == ROLE_REJECTED)
      && out_r.frame_position != 9'd1,
    "length byte reported away from position one")
  `LFCD_ASSERT(a_stall_holds_input,
    !in_tready |-> hold_valid && out_valid_r && !out_tready,
    "input stalled without a full pipeline")

endmodule

FILE: tb/length_framed_crc16_deframer_core_test.sv
// self-checking testbench for the length framed crc16 deframer core
// predicts every tagged byte and checks it against the result stream; random idling on both sides
// depends on lfcd_pkg and length_framed_crc16_deframer_core
module length_framed_crc16_deframer_core_test;
  import lfcd_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int QUIET_TAIL = 300;
  localparam int RESULT_LATENCY = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    HUNT_HEADER,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CRC_LO,
    TAKE_CRC_HI
  } deframe_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'd0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [23:0]          out_tdata;
  logic [3:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'd0;

  lfcd_cfg_t      regs_shadow;
  deframe_phase_t st_phase;
  logic [7:0]     st_left;
  logic [8:0]     st_pos;
  logic [15:0]    st_crc;
  logic [7:0]     st_crc_lo;

  lfcd_res_t tagged_bytes_q[$];
  int        error_count = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  int        sink_stall_left = 0;
  bit        jitter_on = 1'b1;
  int        seen_good = 0;
  int        seen_bad = 0;
  int        seen_rejected = 0;
  int        seen_discarded = 0;
  int        cfg_writes = 0;

  length_framed_crc16_deframer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(posedge clk) begin
    if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      out_tready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 4) == 0) begin
      sink_stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic lfcd_res_t deframe_byte(input logic [7:0] b);
    lfcd_res_t r;
    r.echo_byte = b;
    r.byte_role = ROLE_DISCARD;
    r.frame_position = 9'd0;
    r.frame_good = 1'b0;
    case (st_phase)
      TAKE_LENGTH: begin
        st_pos = 9'd1;
        r.frame_position = 9'd1;
        if (b != 8'd0 && b >= regs_shadow.min_length && b <= regs_shadow.max_length) begin
          r.byte_role = ROLE_LENGTH;
          st_left = b;
          st_crc = crc16_ccitt_byte(16'hFFFF, b);
          st_phase = TAKE_PAYLOAD;
        end else begin
          r.byte_role = ROLE_REJECTED;
          st_phase = HUNT_HEADER;
        end
      end
      TAKE_PAYLOAD: begin
        st_pos = st_pos + 9'd1;
        r.frame_position = st_pos;
        r.byte_role = ROLE_PAYLOAD;
        st_crc = crc16_ccitt_byte(st_crc, b);
        st_left = st_left - 8'd1;
        if (st_left == 8'd0) st_phase = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        st_pos = st_pos + 9'd1;
        r.frame_position = st_pos;
        r.byte_role = ROLE_CRC_LO;
        st_crc_lo = b;
        st_phase = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        st_pos = st_pos + 9'd1;
        r.frame_position = st_pos;
        r.byte_role = ROLE_CRC_HI;
        r.frame_good = ({b, st_crc_lo} == st_crc);
        st_phase = HUNT_HEADER;
      end
      default: begin
        st_pos = 9'd0;
        st_phase = HUNT_HEADER;
        if (b == regs_shadow.header_value) begin
          r.byte_role = ROLE_HEADER;
          st_crc = 16'hFFFF;
          st_phase = TAKE_LENGTH;
        end
      end
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    lfcd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tagged_bytes_q.size() == 0) begin
        $display("%0t: result with none expected, tdata %h tuser %h", $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        want = tagged_bytes_q.pop_front();
        if (out_tdata[7:0] !== want.echo_byte) begin
          $display("%0t: echo_byte expected %h got %h", $time, want.echo_byte, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[16:8] !== want.frame_position) begin
          $display("%0t: frame_position expected %0d got %0d", $time, want.frame_position,
                   out_tdata[16:8]);
          error_count++;
        end
        if (out_tdata[23:17] !== 7'd0) begin
          $display("%0t: tdata padding expected 0 got %h", $time, out_tdata[23:17]);
          error_count++;
        end
        if (out_tuser[2:0] !== want.byte_role) begin
          $display("%0t: byte_role expected %0d got %0d", $time, want.byte_role, out_tuser[2:0]);
          error_count++;
        end
        if (out_tuser[3] !== want.frame_good) begin
          $display("%0t: frame_good expected %b got %b", $time, want.frame_good, out_tuser[3]);
          error_count++;
        end
        case (want.byte_role)
          ROLE_CRC_HI: if (want.frame_good) seen_good++; else seen_bad++;
          ROLE_REJECTED: seen_rejected++;
          ROLE_DISCARD: seen_discarded++;
          default: ;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tagged_bytes_q.push_back(deframe_byte(b));
    items_sent++;
  endtask

  task automatic wait_results_drained;
    in_tvalid <= 1'b0;
    while (tagged_bytes_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_IDX_HEADER: regs_shadow.header_value = val;
      CFG_IDX_MIN:    regs_shadow.min_length = val;
      CFG_IDX_MAX:    regs_shadow.max_length = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // header, length, payload and crc; corrupt flips crc bits
  task automatic send_frame(input logic [7:0] len, input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = crc16_ccitt_byte(16'hFFFF, len);
    send_byte(regs_shadow.header_value);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      crc = crc16_ccitt_byte(crc, b);
      send_byte(b);
    end
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic test_default_registers;
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'h00);
    send_frame(8'd1, 1'b0);
    send_frame(8'd2, 1'b1);
    send_byte(8'hFF);
  endtask

  task automatic test_register_extremes;
    wait_results_drained();
    cfg_write(CFG_IDX_HEADER, 8'hFF);
    cfg_write(CFG_IDX_MIN, 8'd255);
    cfg_write(CFG_IDX_MAX, 8'd255);
    send_byte(8'hFF);
    send_byte(8'hFE);
    wait_results_drained();
    cfg_write(CFG_IDX_MIN, 8'd3);
    cfg_write(CFG_IDX_MAX, 8'd2);
    send_byte(8'hFF);
    send_byte(8'd3);
    send_byte(8'hFF);
    send_byte(8'd2);
    wait_results_drained();
    cfg_write(CFG_IDX_UNUSED, 8'h00);
    cfg_write(CFG_IDX_MIN, 8'd1);
    cfg_write(CFG_IDX_MAX, 8'd1);
    send_byte(8'h00);
    send_frame(8'd1, 1'b0);
    send_byte(8'hFF);
    send_byte(8'd2);
  endtask

  task automatic test_random_traffic;
    int          phase_end;
    int          pick;
    int          lo;
    int          hi;
    logic [7:0]  len;
    bit          range_ok;
    while (items_sent < ITEM_TARGET) begin
      wait_results_drained();
      cfg_write(CFG_IDX_HEADER, 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 11);
      case (pick)
        0, 1: begin lo = 1; hi = 255; end
        2: begin lo = $urandom_range(1, 20); hi = lo; end
        3: begin lo = $urandom_range(2, 255); hi = $urandom_range(0, lo - 1); end
        4: begin lo = 0; hi = $urandom_range(1, 30); end
        11: begin lo = $urandom_range(250, 255); hi = 255; end
        default: begin lo = $urandom_range(1, 10); hi = lo + $urandom_range(0, 20); end
      endcase
      cfg_write(CFG_IDX_MIN, 8'(lo));
      cfg_write(CFG_IDX_MAX, 8'(hi));
      if ($urandom_range(0, 5) == 0) cfg_write(CFG_IDX_UNUSED, 8'($urandom_range(0, 255)));
      if (lo == 0) lo = 1;
      range_ok = (lo <= hi);
      jitter_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
      phase_end = items_sent + $urandom_range(60, 160);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) len = 8'(hi);
        else len = 8'($urandom_range(lo, (hi < lo + 15) ? hi : lo + 15));
        if (pick < 7 && range_ok) begin
          send_frame(len, $urandom_range(0, 3) == 0);
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick == 9 && range_ok) begin
          send_byte(regs_shadow.header_value);
          send_byte(len);
          repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          do len = 8'($urandom_range(0, 255));
          while (len != 0 && len >= regs_shadow.min_length && len <= regs_shadow.max_length);
          send_byte(regs_shadow.header_value);
          send_byte(len);
        end
      end
    end
    jitter_on = 1'b0;
  endtask

  initial begin
    regs_shadow.header_value = 8'h00;
    regs_shadow.min_length = 8'd1;
    regs_shadow.max_length = 8'd255;
    st_phase = HUNT_HEADER;
    st_left = 8'd0;
    st_pos = 9'd0;
    st_crc = 16'hFFFF;
    st_crc_lo = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_register_extremes();
    test_random_traffic();
    wait_results_drained();
    $display("run covered %0d bytes and %0d register writes", items_sent, cfg_writes);
    $display("frames with good crc %0d, bad crc %0d, rejected lengths %0d, discarded bytes %0d",
             seen_good, seen_bad, seen_rejected, seen_discarded);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
